FILE: rtl/matrix_keypad_scanner_assert.svh
// ----------------------------------------------------------------------------
// keypad scanner assertion macros
// shared assertion forms for the keypad scanner rtl
// ----------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_SCANNER_ASSERT_SVH
`define MATRIX_KEYPAD_SCANNER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MKS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define MKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mks_pkg.sv
// ----------------------------------------------------------------------------
// keypad scanner package
// types, register map, phase codes and key table for the keypad scanner
// ----------------------------------------------------------------------------
package mks_pkg;

	localparam int TICK_COUNT_BITS = 16;
	localparam int CFG_W = 16;
	localparam int CMP_W = (TICK_COUNT_BITS > CFG_W) ? TICK_COUNT_BITS : CFG_W;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [TICK_COUNT_BITS-1:0] CNT_MAX = {TICK_COUNT_BITS{1'b1}};
	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = CFG_W'(20);

	// register index is paddr[2]
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_WAIT_RELEASE = 3'd1;
	localparam logic [2:0] PH_DEB_RELEASE = 3'd2;
	localparam logic [2:0] PH_WAIT_PRESS = 3'd3;
	localparam logic [2:0] PH_DEB_PRESS = 3'd4;
	localparam logic [2:0] PH_SCAN = 3'd5;

	localparam logic [3:0] ROWS_NONE = 4'hf;
	localparam logic [2:0] DRIVE_ALL_LOW = 3'b000;
	localparam logic [6:0] CHAR_TIMEOUT = 7'h54;

	typedef logic [TICK_COUNT_BITS-1:0] cnt_t;

	typedef struct packed {
		logic read_request;
		logic [3:0] row_lines;
	} mks_in_t;

	typedef struct packed {
		logic [2:0] column_drive;
		logic key_valid;
		logic [6:0] key_char;
		logic timed_out;
		logic busy_res;
	} mks_out_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		sat_inc = (v == CNT_MAX) ? v : v + cnt_t'(1);
	endfunction

	// a saturated counter counts as reached
	function automatic logic reached(input cnt_t count, input logic [CFG_W-1:0] limit);
		reached = (CMP_W'(count) >= CMP_W'(limit)) || (count == CNT_MAX);
	endfunction

	function automatic logic [1:0] first_low_row(input logic [3:0] rows);
		if (!rows[0]) begin
			first_low_row = 2'd0;
		end else if (!rows[1]) begin
			first_low_row = 2'd1;
		end else if (!rows[2]) begin
			first_low_row = 2'd2;
		end else if (!rows[3]) begin
			first_low_row = 2'd3;
		end else begin
			first_low_row = 2'd0;
		end
	endfunction

	function automatic logic [2:0] column_pattern(input logic [1:0] col);
		column_pattern = ~(3'b001 << col);
	endfunction

	function automatic logic [6:0] key_of(input logic [1:0] col, input logic [1:0] row);
		logic [6:0] ch;
		ch = 7'h00;
		case ({col, row})
			4'b00_00: ch = 7'h31; // 1
			4'b00_01: ch = 7'h34; // 4
			4'b00_10: ch = 7'h37; // 7
			4'b00_11: ch = 7'h2a; // *
			4'b01_00: ch = 7'h32; // 2
			4'b01_01: ch = 7'h35; // 5
			4'b01_10: ch = 7'h38; // 8
			4'b01_11: ch = 7'h30; // 0
			4'b10_00: ch = 7'h33; // 3
			4'b10_01: ch = 7'h36; // 6
			4'b10_10: ch = 7'h39; // 9
			4'b10_11: ch = 7'h23; // #
			default: ch = 7'h00;
		endcase
		key_of = ch;
	endfunction

endpackage

FILE: rtl/mks_in_if.sv
// ----------------------------------------------------------------------------
// keypad sample channel
// valid/ready channel carrying one row sample tick per beat
// ----------------------------------------------------------------------------
interface mks_in_if;
	import mks_pkg::*;

	logic valid;
	logic ready;
	mks_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/mks_out_if.sv
// ----------------------------------------------------------------------------
// keypad result channel
// valid/ready channel carrying one scanner result per beat
// ----------------------------------------------------------------------------
interface mks_out_if;
	import mks_pkg::*;

	logic valid;
	logic ready;
	mks_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/matrix_keypad_scanner.sv
// ----------------------------------------------------------------------------
// matrix keypad scanner
// 4x3 keypad read sequencer with debounce, column scan and optional timeout
// ----------------------------------------------------------------------------
// Every sample beat taken on in_ch gives exactly one result beat on out_ch.
// A sample is registered into s1 on acceptance; its result is written from s1
// into the output register once that register is free or its result is taken.
// One sample is accepted per clock cycle while results are taken; the output
// register lets the next sample in while a finished result waits. The keypad
// state lives in a handful of registers updated together with the output
// register when a sample advances. debounce_ticks and timeout_ticks are
// written over the APB port at byte addresses 0 and 4 and should only change
// while no read is in progress.

module matrix_keypad_scanner (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [mks_pkg::ADDR_W-1:0] paddr,
	input logic [mks_pkg::DATA_W-1:0] pwdata,
	output logic [mks_pkg::DATA_W-1:0] prdata,
	output logic pready,
	mks_in_if.sink in_ch,
	mks_out_if.source out_ch
);
	import mks_pkg::*;
	`include "matrix_keypad_scanner_assert.svh"

	logic [CFG_W-1:0] debounce_ticks_q;
	logic [CFG_W-1:0] timeout_ticks_q;

	logic valid_s1;
	mks_in_t sample_s1;

	logic out_valid_q;
	mks_out_t out_data_q;

	logic [2:0] phase_q, phase_d;
	cnt_t debounce_count_q, debounce_count_d;
	cnt_t elapsed_count_q, elapsed_count_d;
	logic [1:0] pressed_row_q, pressed_row_d;
	logic [1:0] scan_column_q, scan_column_d;
	mks_out_t res;

	logic advance;
	logic cfg_wr;
	cnt_t elapsed_inc;
	logic [1:0] col;
	logic waiting;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= DEBOUNCE_RESET;
			timeout_ticks_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_DEBOUNCE: debounce_ticks_q <= pwdata[CFG_W-1:0];
				REG_TIMEOUT: timeout_ticks_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_DEBOUNCE: prdata = DATA_W'(debounce_ticks_q);
			REG_TIMEOUT: prdata = DATA_W'(timeout_ticks_q);
			default: prdata = '0;
		endcase
	end

	// handshake: s1 moves into the output register when that is free
	assign advance = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			sample_s1 <= in_ch.data;
		end
	end

	// next state and result for the sample in s1
	assign elapsed_inc = sat_inc(elapsed_count_q);
	assign col = (scan_column_q > 2'd2) ? 2'd2 : scan_column_q;
	assign waiting = (phase_q == PH_WAIT_RELEASE) || (phase_q == PH_WAIT_PRESS);

	always_comb begin
		phase_d = phase_q;
		debounce_count_d = debounce_count_q;
		elapsed_count_d = elapsed_count_q;
		pressed_row_d = pressed_row_q;
		scan_column_d = scan_column_q;
		res.column_drive = DRIVE_ALL_LOW;
		res.key_valid = 1'b0;
		res.key_char = '0;
		res.timed_out = 1'b0;

		if (phase_q < PH_WAIT_RELEASE || phase_q > PH_SCAN) begin
			phase_d = PH_IDLE;
			if (sample_s1.read_request) begin
				phase_d = PH_WAIT_RELEASE;
				elapsed_count_d = '0;
				debounce_count_d = '0;
			end
		end else begin
			elapsed_count_d = elapsed_inc;
			if (waiting && timeout_ticks_q != '0 && reached(elapsed_inc, timeout_ticks_q)) begin
				res.key_valid = 1'b1;
				res.key_char = CHAR_TIMEOUT;
				res.timed_out = 1'b1;
				phase_d = PH_IDLE;
			end else begin
				unique case (phase_q)
					PH_WAIT_RELEASE: begin
						if (sample_s1.row_lines == ROWS_NONE) begin
							phase_d = PH_DEB_RELEASE;
							debounce_count_d = '0;
						end
					end
					PH_DEB_RELEASE: begin
						if (reached(debounce_count_q, debounce_ticks_q)) begin
							phase_d = PH_WAIT_PRESS;
						end else begin
							debounce_count_d = sat_inc(debounce_count_q);
						end
					end
					PH_WAIT_PRESS: begin
						if (sample_s1.row_lines != ROWS_NONE) begin
							phase_d = PH_DEB_PRESS;
							debounce_count_d = '0;
						end
					end
					PH_DEB_PRESS: begin
						if (sample_s1.row_lines == ROWS_NONE) begin
							phase_d = PH_WAIT_PRESS;
						end else if (reached(debounce_count_q, debounce_ticks_q)) begin
							pressed_row_d = first_low_row(sample_s1.row_lines);
							scan_column_d = 2'd0;
							phase_d = PH_SCAN;
							res.column_drive = column_pattern(2'd0);
						end else begin
							debounce_count_d = sat_inc(debounce_count_q);
						end
					end
					default: begin
						// column scan: rows answer the pattern sent last beat
						if (sample_s1.row_lines != ROWS_NONE) begin
							res.key_valid = 1'b1;
							res.key_char = key_of(col, pressed_row_q);
							phase_d = PH_IDLE;
						end else if (col < 2'd2) begin
							scan_column_d = col + 2'd1;
							res.column_drive = column_pattern(col + 2'd1);
						end else begin
							phase_d = PH_WAIT_PRESS;
						end
					end
				endcase
			end
		end
		res.busy_res = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			debounce_count_q <= '0;
			elapsed_count_q <= '0;
			pressed_row_q <= '0;
			scan_column_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q <= phase_d;
				debounce_count_q <= debounce_count_d;
				elapsed_count_q <= elapsed_count_d;
				pressed_row_q <= pressed_row_d;
				scan_column_q <= scan_column_d;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= res;
		end
	end

	`MKS_ASSERT_NEXT(a_phase_holds, clk, arst_n, !advance, $stable(phase_q), "phase moved without a beat")
	`MKS_ASSERT_NOW(a_timeout_char, clk, arst_n, out_valid_q && out_data_q.timed_out, out_data_q.key_valid && out_data_q.key_char == CHAR_TIMEOUT, "timeout result malformed")
	`MKS_ASSERT_NOW(a_key_ends_read, clk, arst_n, out_valid_q && out_data_q.key_valid, !out_data_q.busy_res, "read still busy after its result")
	`MKS_ASSERT_NOW(a_scan_column, clk, arst_n, phase_q == PH_SCAN, scan_column_q <= 2'd2, "scan column out of range")

endmodule
